[rtl/core/vm_pkg.sv]
package vm_pkg;

  // Bits of the radicand consumed by one root digit.
  localparam int unsigned PAIR_BITS = 2;

  // Extra bits that the partial remainder needs beyond the component width.
  localparam int unsigned REM_EXTRA_BITS = 2;

endpackage

[rtl/core/vm_square.sv]
module vm_square #(
  parameter int unsigned W = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  output logic           ready_o,
  input  logic [W-1:0]   x_i,
  input  logic [W-1:0]   y_i,
  output logic           valid_o,
  input  logic           ready_i,
  output logic [2*W-1:0] sum_o
);
  import vm_pkg::*;

  logic           sq_valid_q;
  logic           sq_adv;
  logic [2*W-1:0] sqx_q, sqx_d;
  logic [2*W-1:0] sqy_q, sqy_d;
  logic           sum_valid_q;
  logic           sum_adv;
  logic [2*W-1:0] sum_q;
  logic [W-1:0]   abs_x;
  logic [W-1:0]   abs_y;

  // Absolute values; the most negative code maps onto 2^(W-1), which still fits.
  assign abs_x = x_i[W-1] ? (~x_i + W'(1)) : x_i;
  assign abs_y = y_i[W-1] ? (~y_i + W'(1)) : y_i;

  assign sqx_d = {{W{1'b0}}, abs_x} * {{W{1'b0}}, abs_x};
  assign sqy_d = {{W{1'b0}}, abs_y} * {{W{1'b0}}, abs_y};

  // A stage takes a new transfer when it is empty or its content moves on.
  assign sum_adv = !sum_valid_q || ready_i;
  assign sq_adv  = !sq_valid_q || sum_adv;
  assign ready_o = sq_adv;

  // Square stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_valid_q <= 1'b0;
    end else if (sq_adv) begin
      sq_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sq_adv && valid_i) begin
      sqx_q <= sqx_d;
      sqy_q <= sqy_d;
    end
  end

  // Sum stage; the sum of two squares never exceeds 2^(2W-1).
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_valid_q <= 1'b0;
    end else if (sum_adv) begin
      sum_valid_q <= sq_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sum_adv && sq_valid_q) begin
      sum_q <= sqx_q + sqy_q;
    end
  end

  assign valid_o = sum_valid_q;
  assign sum_o   = sum_q;

endmodule

[rtl/core/vm_sqrt_cell.sv]
module vm_sqrt_cell #(
  parameter int unsigned W = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           valid_i,
  output logic                           ready_o,
  input  logic [2*W-1:0]                 rad_i,
  input  logic [W+vm_pkg::REM_EXTRA_BITS-1:0] rem_i,
  input  logic [W-1:0]                   root_i,
  output logic                           valid_o,
  input  logic                           ready_i,
  output logic [2*W-1:0]                 rad_o,
  output logic [W+vm_pkg::REM_EXTRA_BITS-1:0] rem_o,
  output logic [W-1:0]                   root_o
);
  import vm_pkg::*;

  localparam int unsigned RW = W + REM_EXTRA_BITS;
  localparam int unsigned TW = RW + PAIR_BITS;

  logic          valid_q;
  logic          adv;
  logic [2*W-1:0] rad_q, rad_d;
  logic [RW-1:0] rem_q, rem_d;
  logic [W-1:0]  root_q, root_d;
  logic [TW-1:0] rem_sh;
  logic [TW-1:0] trial;
  logic [TW-1:0] diff;
  logic          take;

  // One root digit: bring down the top pair of the radicand and test the trial.
  assign rem_sh = {rem_i, rad_i[2*W-1 -: PAIR_BITS]};
  assign trial  = {{REM_EXTRA_BITS{1'b0}}, root_i, {(PAIR_BITS-1){1'b0}}, 1'b1};
  assign diff   = rem_sh - trial;
  assign take   = (rem_sh >= trial);

  // The remainder stays below 2^(W+1), so the top bits can be dropped.
  assign rem_d  = take ? diff[RW-1:0] : rem_sh[RW-1:0];
  assign root_d = {root_i[W-2:0], take};
  assign rad_d  = {rad_i[2*W-PAIR_BITS-1:0], {PAIR_BITS{1'b0}}};

  assign adv     = !valid_q || ready_i;
  assign ready_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && valid_i) begin
      rad_q  <= rad_d;
      rem_q  <= rem_d;
      root_q <= root_d;
    end
  end

  assign valid_o = valid_q;
  assign rad_o   = rad_q;
  assign rem_o   = rem_q;
  assign root_o  = root_q;

endmodule

[rtl/core/vector_magnitude.sv]
// Channel  Handshake                   Payload
// -------  --------------------------  ------------------------------------
// in       in_valid_i / in_ready_o     x_value_i, y_value_i (signed, W bits)
// out      out_valid_o / out_ready_i   magnitude_o (unsigned, W bits)
//
// One transfer per cycle is accepted unless a full stage is held by out_ready_i low.
// A square stage and a sum stage come first, then a row of COMPONENT_WIDTH cells
// settles one root digit each; the last cell's register is the output register.
// Each stage holds while the next one is full and stalled, so bubbles close up.
// Reset clears only the valid bits of the stages.
module vector_magnitude #(
  parameter int unsigned COMPONENT_WIDTH = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [COMPONENT_WIDTH-1:0] x_value_i,
  input  logic [COMPONENT_WIDTH-1:0] y_value_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [COMPONENT_WIDTH-1:0] magnitude_o
);
  import vm_pkg::*;

  localparam int unsigned W  = COMPONENT_WIDTH;
  localparam int unsigned RW = W + REM_EXTRA_BITS;

  logic           valid_c [W+1];
  logic           ready_c [W+1];
  logic [2*W-1:0] rad_c   [W+1];
  logic [RW-1:0]  rem_c   [W+1];
  logic [W-1:0]   root_c  [W+1];

  // Absolute values, squares and their sum.
  vm_square #(
    .W (W)
  ) u_square (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (in_ready_o),
    .x_i     (x_value_i),
    .y_i     (y_value_i),
    .valid_o (valid_c[0]),
    .ready_i (ready_c[0]),
    .sum_o   (rad_c[0])
  );

  // The root starts empty with a zero remainder.
  assign rem_c[0]  = '0;
  assign root_c[0] = '0;

  // Row of digit cells, most significant digit first.
  for (genvar k = 0; k < W; k++) begin : g_cell
    vm_sqrt_cell #(
      .W (W)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (valid_c[k]),
      .ready_o (ready_c[k]),
      .rad_i   (rad_c[k]),
      .rem_i   (rem_c[k]),
      .root_i  (root_c[k]),
      .valid_o (valid_c[k+1]),
      .ready_i (ready_c[k+1]),
      .rad_o   (rad_c[k+1]),
      .rem_o   (rem_c[k+1]),
      .root_o  (root_c[k+1])
    );
  end

  assign ready_c[W]  = out_ready_i;
  assign out_valid_o = valid_c[W];
  assign magnitude_o = root_c[W];

endmodule
